// ===== rtl/gqbp_pkg.sv =====
// ----------------------------------------------------------------------------
// gqbp_pkg
// Word types and fixed widths shared by the grey-level quantiser and packer.
// ----------------------------------------------------------------------------
package gqbp_pkg;

  localparam int PIXEL_W = 8;
  localparam int K_W     = 3;
  localparam int BYTE_W  = 8;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_in;
    logic               last_pixel;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic              last_byte;
  } out_t;

endpackage

// ===== rtl/gray_quantize_bit_packer_core.sv =====
// ----------------------------------------------------------------------------
// gray_quantize_bit_packer_core
// Quantises 8-bit grey pixels to k-bit codes and packs them MSB-first.
// ----------------------------------------------------------------------------
// Usage:
//   in_data  : one pixel per word (pixel_in, last_pixel), valid/ready.
//   out_data : one packed byte per word (byte_out, last_byte), valid/ready.
//   cfg_we/cfg_data set the code width k (0 is taken as 1); write only
//   while the block is idle.
// Each accepted pixel keeps its top k bits and appends them to the pending
// byte. A word leaves for every byte completed; on the last pixel any
// remaining bits go out zero-padded, the final word carries last_byte, and
// the packer state clears for the next image.
// A completed byte is registered into the output queue and is presented on
// out_data from there. Throughput: one pixel per cycle while in_ready is high;
// a last pixel that yields two bytes writes both into the queue together.
// Results sit in a four-word output queue; in_ready drops when fewer than
// two slots are free, so a stalled receiver back-pressures the input.
// Reset (rst, synchronous) empties the queue, clears the pending byte and
// sets k to 1.
// ----------------------------------------------------------------------------
module gray_quantize_bit_packer_core
  import gqbp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  in_t            in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output out_t           out_data,
  input  logic           cfg_we,
  input  logic [K_W-1:0] cfg_data
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  logic [K_W-1:0]    bits_per_pixel;
  logic [BYTE_W-1:0] partial_byte;
  logic [K_W-1:0]    fill_bits;

  out_t              queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic [K_W-1:0]      k;
  logic [BYTE_W-1:0]   code;
  logic [K_W:0]        total;
  logic [2*BYTE_W-1:0] acc;
  logic                full;
  logic [BYTE_W-1:0]   partial_byte_next;
  logic [K_W-1:0]      fill_bits_next;
  logic                accept;
  logic                pop;
  logic [1:0]          n_push;
  out_t                word0;
  out_t                word1;

  assign accept    = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign in_ready  = (count <= QCNT_W'(QDEPTH - 2));
  assign out_data  = queue[rd_ptr];

  always_comb begin
    k     = (bits_per_pixel == '0) ? K_W'(1) : bits_per_pixel;
    code  = in_data.pixel_in >> (4'(BYTE_W) - {1'b0, k});
    total = {1'b0, fill_bits} + {1'b0, k};
    // window of 16 bits, pending bits at the top, new code just below them
    acc   = {partial_byte, 8'h00} |
            ({8'h00, code} << (5'd16 - {1'b0, total}));
    full  = (total >= 4'(BYTE_W));
    if (full) begin
      partial_byte_next = acc[BYTE_W-1:0];
      fill_bits_next    = K_W'(total - 4'(BYTE_W));
    end else begin
      partial_byte_next = acc[2*BYTE_W-1:BYTE_W];
      fill_bits_next    = total[K_W-1:0];
    end

    word0 = '0;
    word1 = '0;
    n_push = 2'd0;
    if (full) begin
      word0.byte_out  = acc[2*BYTE_W-1:BYTE_W];
      word0.last_byte = in_data.last_pixel && (fill_bits_next == '0);
      word1.byte_out  = partial_byte_next;
      word1.last_byte = 1'b1;
      n_push = (in_data.last_pixel && (fill_bits_next != '0)) ? 2'd2 : 2'd1;
    end else begin
      word0.byte_out  = partial_byte_next;
      word0.last_byte = 1'b1;
      n_push = in_data.last_pixel ? 2'd1 : 2'd0;
    end
    if (!accept) begin
      n_push = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_pixel <= K_W'(1);
      partial_byte   <= '0;
      fill_bits      <= '0;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      count          <= '0;
    end else begin
      if (cfg_we) begin
        bits_per_pixel <= cfg_data;
      end
      if (accept) begin
        // drop the pending bits once the image is flushed
        if (in_data.last_pixel) begin
          partial_byte <= '0;
          fill_bits    <= '0;
        end else begin
          partial_byte <= partial_byte_next;
          fill_bits    <= fill_bits_next;
        end
      end
      wr_ptr <= wr_ptr + QPTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(n_push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue[wr_ptr] <= word0;
    end
    if (n_push == 2'd2) begin
      queue[wr_ptr + QPTR_W'(1)] <= word1;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("output queue overfilled");

  a_pending_aligned: assert property (@(posedge clk) disable iff (rst)
    (partial_byte & (8'hFF >> fill_bits)) == 8'h00)
    else $error("pending byte has bits below its fill level");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.last_pixel |=> (fill_bits == '0) && (partial_byte == '0))
    else $error("packer state not cleared after last pixel");

  a_last_yields_word: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.last_pixel |=> out_valid)
    else $error("last pixel produced no output word");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grey-level quantiser and MSB-first bit packer.
// Pixels are queued per image and driven with random gaps, or back to back in
// smooth phases. Each accepted pixel is run through a local packer model whose
// expected bytes are compared, in order, with the bytes that leave the block.
// The receiver stalls at random outside smooth phases and once holds off long
// enough to back-pressure the input. The code width is changed between phases
// only while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_top;
  import gqbp_pkg::*;

  localparam int HOLD_LIMIT = 3000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  in_t            in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  out_t           out_data;
  logic           cfg_we = 1'b0;
  logic [K_W-1:0] cfg_data = '0;

  in_t            pixel_q[$];
  out_t           byte_q[$];
  logic [7:0]     pend_byte = '0;
  int unsigned    pend_fill = 0;
  logic [K_W-1:0] code_k = 3'd1;
  int             errors = 0;
  int             pixels_taken = 0;
  int             pixels_queued = 0;
  int             send_gap = 0;
  int             recv_hold = 0;
  int             quiet_cycles = 0;
  bit             smooth = 1'b0;
  bit             squeezed = 1'b0;

  gray_quantize_bit_packer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Quantise one pixel, append its code and queue the bytes it completes or flushes.
  function automatic void pack_pixel(input in_t px);
    int unsigned k;
    int unsigned total;
    logic [7:0]  code;
    logic [15:0] window;
    out_t        word;
    k = (code_k == 0) ? 1 : code_k;
    code = px.pixel_in >> (8 - k);
    total = pend_fill + k;
    window = {pend_byte, 8'h00} | (16'(code) << (16 - total));
    if (total >= 8) begin
      word.byte_out = window[15:8];
      word.last_byte = 1'b0;
      byte_q.push_back(word);
      pend_byte = window[7:0];
      pend_fill = total - 8;
    end else begin
      pend_byte = window[15:8];
      pend_fill = total;
    end
    if (px.last_pixel) begin
      if (pend_fill != 0) begin
        word.byte_out = pend_byte;
        word.last_byte = 1'b0;
        byte_q.push_back(word);
      end
      // the final word of the image carries the end mark
      byte_q[byte_q.size()-1].last_byte = 1'b1;
      pend_byte = '0;
      pend_fill = 0;
    end
  endfunction

  // Check the leaving word first, then predict for the pixel taken.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (byte_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual byte %02h last %0b",
                 $time, out_data.byte_out, out_data.last_byte);
      end else begin
        want = byte_q.pop_front();
        if (out_data.byte_out !== want.byte_out) begin
          errors++;
          $display("%0t: byte_out mismatch, expected %02h, actual %02h",
                   $time, want.byte_out, out_data.byte_out);
        end
        if (out_data.last_byte !== want.last_byte) begin
          errors++;
          $display("%0t: last_byte mismatch, expected %0b, actual %0b",
                   $time, want.last_byte, out_data.last_byte);
        end
      end
    end
    if (!rst && in_valid && in_ready) begin
      pack_pixel(in_data);
      pixels_taken++;
    end
  end

  // Pixel driver: hold the word until taken, then advance or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        in_data <= pixel_q.pop_front();
        in_valid <= 1'b1;
        if (!smooth) send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Byte receiver, with one long hold-off to fill the block.
  always @(posedge clk) begin
    int g;
    if (rst) begin
      out_ready <= 1'b0;
      recv_hold = 0;
    end else if (recv_hold > 0) begin
      recv_hold--;
      out_ready <= 1'b0;
    end else if (!squeezed && pixels_taken >= 400) begin
      squeezed = 1'b1;
      recv_hold = 120;
      out_ready <= 1'b0;
    end else if (smooth) begin
      out_ready <= 1'b1;
    end else begin
      g = pick_gap();
      if (g == 0) begin
        out_ready <= 1'b1;
      end else begin
        recv_hold = g - 1;
        out_ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HOLD_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || byte_q.size() != 0) @(posedge clk);
    // a pixel that completes no byte may still be in the pipe
    repeat (6) @(posedge clk);
  endtask

  task automatic set_width(input logic [K_W-1:0] k);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= k;
    code_k = k;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_pixel(input logic [7:0] p, input logic last);
    in_t px;
    px.pixel_in = p;
    px.last_pixel = last;
    pixel_q.push_back(px);
    pixels_queued++;
  endtask

  function automatic logic [7:0] rand_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_image(input int len, input bit close);
    for (int i = 0; i < len; i++) push_pixel(rand_pixel(), close && (i == len - 1));
  endtask

  initial begin
    int phase;
    int images;
    int len;
    logic [K_W-1:0] k;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero width acts as one bit; eight codes end exactly on a byte
    set_width(3'd0);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h80, 1'b0);
    push_pixel(8'h7F, 1'b0);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'h00, 1'b1);

    // widest codes straddle bytes; the last pixel yields a byte and a flush
    set_width(3'd7);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h80, 1'b0);
    push_pixel(8'h7F, 1'b0);
    push_pixel(8'hAA, 1'b1);

    // single-pixel image, then a short one flushed with padding
    set_width(3'd3);
    push_pixel(8'hE5, 1'b1);
    push_pixel(8'h55, 1'b0);
    push_pixel(8'hFF, 1'b1);

    phase = 0;
    while (pixels_queued < 1216) begin
      k = (phase == 0) ? 3'd1 : (phase == 1) ? 3'd7 : K_W'($urandom_range(0, 7));
      set_width(k);
      smooth = ($urandom_range(0, 3) == 0);
      images = $urandom_range(1, 5);
      for (int i = 0; i < images; i++) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 20);
        // leave some images open so the pending bits carry across a width change
        push_image(len, (i < images - 1) || ($urandom_range(0, 9) >= 3));
      end
      phase++;
    end

    wait_idle();
    smooth = 1'b0;
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gqbp_pkg.sv
rtl/gray_quantize_bit_packer_core.sv
tb/tb_top.sv
